@@ rtl/hid_apdu_packet_deframer_core_defines.svh @@
// Assertion macros for the HID APDU packet deframer.
`ifndef HID_APDU_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define HID_APDU_PACKET_DEFRAMER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define HAPDU_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hapdu assertion failed");
`define HAPDU_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("hapdu forbidden condition seen");
`else
`define HAPDU_ASSERT(lbl, prop)
`define HAPDU_ASSERT_NEVER(lbl, cond)
`endif
`endif

@@ rtl/hapdu_pkg.sv @@
// Package: constants and types for the HID APDU packet deframer.
`timescale 1ns / 1ps
`default_nettype none
package hapdu_pkg;
   localparam int PACKET_BYTES = 64;
   localparam int APDU_MAX     = 4096;
   localparam int MIN_APDU_LEN = 5;

   localparam int POS_W = $clog2(PACKET_BYTES);
   localparam int LEN_W = 13;
   localparam int OFF_W = 12;

   typedef logic [POS_W-1:0] pos_type;

   localparam pos_type POS_CHAN_HI    = POS_W'(0);
   localparam pos_type POS_CHAN_LO    = POS_W'(1);
   localparam pos_type POS_TAG        = POS_W'(2);
   localparam pos_type POS_SEQ_HI     = POS_W'(3);
   localparam pos_type POS_SEQ_LO     = POS_W'(4);
   localparam pos_type POS_LEN_HI     = POS_W'(5);
   localparam pos_type POS_LEN_LO     = POS_W'(6);
   localparam pos_type POS_DATA_CONT  = POS_W'(5);
   localparam pos_type POS_DATA_FIRST = POS_W'(7);
   localparam pos_type POS_LAST       = POS_W'(PACKET_BYTES - 1);

   localparam logic [7:0] TAG_RESET = 8'd5;

   typedef enum logic [1:0] {
      ST_MORE     = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_ERROR    = 2'd2
   } frame_status_type;

   // register indexes (word address bit 2)
   localparam logic REG_APDU_TAG = 1'b0;
endpackage
`default_nettype wire

@@ rtl/hid_apdu_packet_deframer_core.sv @@
// Top level: HID APDU packet deframer core.
// Usage:
//  - req channel: one raw byte of the HID report stream per item, packets of
//    PACKET_BYTES bytes back to back (channel, tag, sequence, [length], data).
//  - rsp channel: one item per input byte: payload byte and its APDU offset
//    when data_valid, and on the packet's last byte packet_done with
//    frame_status (need more / complete / error) and apdu_length.
//  - csr port: APB-style, register 0 at byte address 0 is apdu_tag (reset 5).
//    Write it only while the block is idle.
// Path: a byte accepted lands in the input register; its result is then
//  registered in the result register and offered on rsp from then on.
// Throughput: one item per cycle unless rsp_stall holds. The header/session
//  update for a byte is one pass of logic between the input register and the
//  result register, with the packet position counter selecting the field.
// Reset (synchronous): clears the position counter, the session and the
//  header capture; apdu_tag returns to 5. No item is offered after reset.
// Stall: while rsp_stall holds, the result register keeps its item and one
//  more byte can sit in the input register; after that req_stall rises.
`timescale 1ns / 1ps
`default_nettype none
`include "hid_apdu_packet_deframer_core_defines.svh"
module hid_apdu_packet_deframer_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_rx_byte,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_data_valid,
   output logic [7:0]                          rsp_data_byte,
   output logic [hapdu_pkg::OFF_W-1:0]         rsp_payload_offset,
   output logic                                rsp_packet_done,
   output hapdu_pkg::frame_status_type         rsp_frame_status,
   output logic [hapdu_pkg::LEN_W-1:0]         rsp_apdu_length,
   // configuration port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [2:0]                     csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import hapdu_pkg::*;

   // ---------------- configuration ----------------
   logic [7:0] tag_ff, tag_in;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      tag_in = tag_ff;
      if (csr_wr && csr_paddr[2] == REG_APDU_TAG) begin
         tag_in = csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == REG_APDU_TAG) begin
         csr_prdata = {24'd0, tag_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= TAG_RESET;
      end else begin
         tag_ff <= tag_in;
      end
   end

   // ---------------- handshake ----------------
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       advance;   // input register item moves into the result register
   logic       req_take;
   logic       rsp_take;

   assign rsp_take  = rsp_valid & ~rsp_stall;
   assign advance   = s1_valid_ff & (~rsp_valid | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_rx_byte;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------- deframer state ----------------
   pos_type          pos_ff, pos_in;
   logic             active_ff, active_in;
   logic [15:0]      chan_ff, chan_in;
   logic [15:0]      nseq_ff, nseq_in;
   logic [LEN_W-1:0] explen_ff, explen_in;
   logic [LEN_W-1:0] copied_ff, copied_in;
   logic [15:0]      hchan_ff, hchan_in;
   logic [15:0]      hseq_ff, hseq_in;
   logic [7:0]       lenhi_ff, lenhi_in;
   logic             failed_ff, failed_in;

   // result next values
   logic             o_dvalid;
   logic [7:0]       o_dbyte;
   logic [OFF_W-1:0] o_doff;
   logic             o_done;
   frame_status_type o_status;
   logic [LEN_W-1:0] o_alen;

   logic [7:0]       b;
   logic [15:0]      len_word;
   pos_type          data_start;

   assign b        = s1_byte_ff;
   assign len_word = {lenhi_ff, b};

   always_comb begin
      pos_in     = pos_ff;
      active_in  = active_ff;
      chan_in    = chan_ff;
      nseq_in    = nseq_ff;
      explen_in  = explen_ff;
      copied_in  = copied_ff;
      hchan_in   = hchan_ff;
      hseq_in    = hseq_ff;
      lenhi_in   = lenhi_ff;
      failed_in  = failed_ff;
      o_dvalid   = 1'b0;
      o_dbyte    = 8'd0;
      o_doff     = '0;
      o_done     = 1'b0;
      o_status   = ST_MORE;
      o_alen     = '0;
      data_start = POS_DATA_CONT;

      // header fields by position in the packet
      case (pos_ff)
         POS_CHAN_HI: begin
            failed_in = 1'b0;
            hchan_in  = {b, 8'h00};
         end
         POS_CHAN_LO: begin
            hchan_in = {hchan_ff[15:8], b};
         end
         POS_TAG: begin
            if (!failed_ff && b != tag_ff) begin
               failed_in = 1'b1;
               active_in = 1'b0;
               chan_in   = '0;
               nseq_in   = '0;
               explen_in = '0;
               copied_in = '0;
            end
         end
         POS_SEQ_HI: begin
            hseq_in = {b, 8'h00};
         end
         POS_SEQ_LO: begin
            hseq_in = {hseq_ff[15:8], b};
            if (!failed_ff && hseq_in != 16'd0) begin
               if (!active_ff || hchan_ff != chan_ff || hseq_in != nseq_ff) begin
                  failed_in = 1'b1;
                  active_in = 1'b0;
                  chan_in   = '0;
                  nseq_in   = '0;
                  explen_in = '0;
                  copied_in = '0;
               end else begin
                  nseq_in = nseq_ff + 16'd1;
               end
            end
         end
         POS_LEN_HI: begin
            if (hseq_ff == 16'd0) begin
               lenhi_in = b;
            end
         end
         POS_LEN_LO: begin
            if (hseq_ff == 16'd0 && !failed_ff) begin
               // first packet: restart the session
               active_in = 1'b0;
               chan_in   = '0;
               nseq_in   = '0;
               explen_in = '0;
               copied_in = '0;
               if (len_word < 16'(MIN_APDU_LEN) || len_word > 16'(APDU_MAX)) begin
                  failed_in = 1'b1;
               end else begin
                  active_in = 1'b1;
                  chan_in   = hchan_ff;
                  nseq_in   = 16'd1;
                  explen_in = len_word[LEN_W-1:0];
               end
            end
         end
         default: ;
      endcase

      // payload bytes up to the expected length
      if (hseq_in == 16'd0) begin
         data_start = POS_DATA_FIRST;
      end
      if (pos_ff >= data_start && !failed_in && active_in && copied_in < explen_in) begin
         o_dvalid  = 1'b1;
         o_dbyte   = b;
         o_doff    = copied_in[OFF_W-1:0];
         copied_in = copied_in + LEN_W'(1);
      end

      // last byte of the packet reports the outcome
      if (pos_ff == POS_LAST) begin
         o_done = 1'b1;
         pos_in = '0;
         if (failed_in) begin
            o_status = ST_ERROR;
         end else begin
            o_status = (copied_in == explen_in) ? ST_COMPLETE : ST_MORE;
            o_alen   = copied_in;
         end
      end else begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pos_ff      <= '0;
         active_ff   <= 1'b0;
         chan_ff     <= '0;
         nseq_ff     <= '0;
         explen_ff   <= '0;
         copied_ff   <= '0;
         hchan_ff    <= '0;
         hseq_ff     <= '0;
         lenhi_ff    <= '0;
         failed_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            pos_ff    <= pos_in;
            active_ff <= active_in;
            chan_ff   <= chan_in;
            nseq_ff   <= nseq_in;
            explen_ff <= explen_in;
            copied_ff <= copied_in;
            hchan_ff  <= hchan_in;
            hseq_ff   <= hseq_in;
            lenhi_ff  <= lenhi_in;
            failed_ff <= failed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
   end

   // ---------------- result register ----------------
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_valid     <= o_dvalid;
         rsp_data_byte      <= o_dbyte;
         rsp_payload_offset <= o_doff;
         rsp_packet_done    <= o_done;
         rsp_frame_status   <= o_status;
         rsp_apdu_length    <= o_alen;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- assertions ----------------
   `HAPDU_ASSERT_NEVER(a_copied_le_expected, copied_ff > explen_ff)
   `HAPDU_ASSERT(a_idle_session_empty, !active_ff |-> (explen_ff == '0 && copied_ff == '0))
   `HAPDU_ASSERT_NEVER(a_pos_in_range, pos_ff > POS_LAST)
   `HAPDU_ASSERT_NEVER(a_no_data_on_error, rsp_valid && rsp_data_valid && rsp_packet_done && rsp_frame_status == ST_ERROR)
endmodule
`default_nettype wire

@@ tb/hid_apdu_packet_deframer_core_test.sv @@
// Self-checking testbench for the HID APDU packet deframer core.
`timescale 1ns / 1ps
module hid_apdu_packet_deframer_core_test;
   import hapdu_pkg::*;

   // payload pattern of a generated packet
   typedef enum logic [1:0] {
      FILL_RAMP   = 2'd0,
      FILL_ZERO   = 2'd1,
      FILL_ONES   = 2'd2,
      FILL_RANDOM = 2'd3
   } fill_kind_type;

   // one row of the directed table: a whole packet and, when typed is set,
   // the status and length its last byte must report
   typedef struct packed {
      logic [15:0]      chan;
      logic [7:0]       tag;
      logic [15:0]      seq;
      logic [15:0]      len;
      fill_kind_type    fill;
      logic             typed;
      frame_status_type status;
      logic [LEN_W-1:0] total;
   } packet_row_type;

   // what the block gives out for one byte
   typedef struct packed {
      logic             data_valid;
      logic [7:0]       data_byte;
      logic [OFF_W-1:0] payload_offset;
      logic             packet_done;
      frame_status_type frame_status;
      logic [LEN_W-1:0] apdu_length;
   } deframe_result_type;

   localparam logic [2:0] TAG_ADDR  = {REG_APDU_TAG, 2'b00};
   localparam int         DIR_ROWS  = 17;
   localparam int         FIRST_CAP = PACKET_BYTES - int'(POS_DATA_FIRST);
   localparam int         CONT_CAP  = PACKET_BYTES - int'(POS_DATA_CONT);

   // ------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_rx_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_data_valid;
   logic [7:0]          rsp_data_byte;
   logic [OFF_W-1:0]    rsp_payload_offset;
   logic                rsp_packet_done;
   frame_status_type    rsp_frame_status;
   logic [LEN_W-1:0]    rsp_apdu_length;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [2:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   hid_apdu_packet_deframer_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_packet_done    (rsp_packet_done),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_apdu_length    (rsp_apdu_length),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Deframer shadow: own copy of the tag register, packet position,
   // header capture and session state
   // ------------------------------------------------------------------
   logic [7:0]       apdu_tag_shadow;
   pos_type          rx_pos;
   logic             sess_active;
   logic [15:0]      sess_channel;
   logic [15:0]      sess_next_seq;
   logic [LEN_W-1:0] sess_expected_len;
   logic [LEN_W-1:0] sess_copied_len;
   logic [15:0]      hdr_channel;
   logic [15:0]      hdr_seq;
   logic [7:0]       hdr_len_hi;
   logic             pkt_failed;

   deframe_result_type expected_results [$];
   deframe_result_type exp_r;
   int                 mismatch_count = 0;
   int                 bytes_accepted = 0;
   bit                 sender_burst   = 1'b0;

   function automatic void clear_session();
      sess_active       = 1'b0;
      sess_channel      = '0;
      sess_next_seq     = '0;
      sess_expected_len = '0;
      sess_copied_len   = '0;
   endfunction

   function automatic void reset_deframer_shadow();
      apdu_tag_shadow = TAG_RESET;
      rx_pos          = '0;
      hdr_channel     = '0;
      hdr_seq         = '0;
      hdr_len_hi      = '0;
      pkt_failed      = 1'b0;
      clear_session();
   endfunction

   // advances the shadow by one stream byte and returns the block's output
   function automatic deframe_result_type deframe_byte(input logic [7:0] b);
      deframe_result_type r;
      logic [15:0]        len;
      pos_type            data_start;
      r   = '0;
      len = {hdr_len_hi, b};
      if (rx_pos == POS_CHAN_HI) begin
         pkt_failed  = 1'b0;
         hdr_channel = {b, 8'h00};
      end else if (rx_pos == POS_CHAN_LO) begin
         hdr_channel[7:0] = b;
      end else if (rx_pos == POS_TAG) begin
         if (!pkt_failed && b != apdu_tag_shadow) begin
            pkt_failed = 1'b1;
            clear_session();
         end
      end else if (rx_pos == POS_SEQ_HI) begin
         hdr_seq = {b, 8'h00};
      end else if (rx_pos == POS_SEQ_LO) begin
         hdr_seq[7:0] = b;
         // continuation packet: must follow the open session exactly
         if (!pkt_failed && hdr_seq != 16'd0) begin
            if (!sess_active || hdr_channel != sess_channel || hdr_seq != sess_next_seq) begin
               pkt_failed = 1'b1;
               clear_session();
            end else begin
               sess_next_seq = sess_next_seq + 16'd1;
            end
         end
      end else if (rx_pos == POS_LEN_HI && hdr_seq == 16'd0) begin
         hdr_len_hi = b;
      end else if (rx_pos == POS_LEN_LO && hdr_seq == 16'd0) begin
         // opening packet: length decides, old session is gone either way
         if (!pkt_failed) begin
            clear_session();
            if (len < MIN_APDU_LEN || len > APDU_MAX) begin
               pkt_failed = 1'b1;
            end else begin
               sess_active       = 1'b1;
               sess_channel      = hdr_channel;
               sess_next_seq     = 16'd1;
               sess_expected_len = len[LEN_W-1:0];
            end
         end
      end

      data_start = (hdr_seq == 16'd0) ? POS_DATA_FIRST : POS_DATA_CONT;
      if (rx_pos >= data_start && !pkt_failed && sess_active &&
          sess_copied_len < sess_expected_len) begin
         r.data_valid     = 1'b1;
         r.data_byte      = b;
         r.payload_offset = sess_copied_len[OFF_W-1:0];
         sess_copied_len  = sess_copied_len + 1'b1;
      end

      if (rx_pos == POS_LAST) begin
         r.packet_done = 1'b1;
         if (pkt_failed) begin
            r.frame_status = ST_ERROR;
         end else begin
            r.frame_status = (sess_copied_len == sess_expected_len) ? ST_COMPLETE : ST_MORE;
            r.apdu_length  = sess_copied_len;
         end
         rx_pos = '0;
      end else begin
         rx_pos = rx_pos + 1'b1;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Mismatch reporting
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   // ------------------------------------------------------------------
   // Result checker: every accepted rsp item against the oldest expectation.
   // Sampled at the edge, so outputs are read with their pre-edge values.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result item with nothing expected");
         end else begin
            exp_r = expected_results.pop_front();
            check_field("data_valid", int'(rsp_data_valid), int'(exp_r.data_valid));
            check_field("data_byte", int'(rsp_data_byte), int'(exp_r.data_byte));
            check_field("payload_offset", int'(rsp_payload_offset),
                        int'(exp_r.payload_offset));
            check_field("packet_done", int'(rsp_packet_done), int'(exp_r.packet_done));
            check_field("frame_status", int'(rsp_frame_status), int'(exp_r.frame_status));
            check_field("apdu_length", int'(rsp_apdu_length), int'(exp_r.apdu_length));
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stall before each item, with occasional stretches
   // of no stall at all
   // ------------------------------------------------------------------
   initial begin
      int n;
      int quiet_left;
      quiet_left = 0;
      rsp_stall  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (quiet_left > 0) begin
            n = 0;
            quiet_left--;
         end else if ($urandom_range(0, 29) == 0) begin
            n          = 0;
            quiet_left = $urandom_range(20, 80);
         end else begin
            n = $urandom_range(0, 19);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   // one byte over req; on accept the shadow predicts its result. A typed
   // row overrides the predicted status and length of the packet's last byte.
   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input frame_status_type st, input logic [LEN_W-1:0] total);
      int                 gap;
      deframe_result_type r;
      gap = sender_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_accepted++;
      r = deframe_byte(b);
      if (typed && r.packet_done) begin
         r.frame_status = st;
         r.apdu_length  = total;
      end
      expected_results.push_back(r);
   endtask

   // builds one HID report: channel, tag, sequence, length on sequence 0,
   // then the payload pattern
   task automatic send_packet(input logic [15:0] chan, input logic [7:0] tag,
                              input logic [15:0] seq, input logic [15:0] len,
                              input fill_kind_type fill, input logic typed = 1'b0,
                              input frame_status_type st = ST_MORE,
                              input logic [LEN_W-1:0] total = '0);
      int         p;
      pos_type    q;
      logic [7:0] b;
      sender_burst = ($urandom_range(0, 3) == 0);
      for (p = 0; p < PACKET_BYTES; p++) begin
         q = pos_type'(p);
         if (q == POS_CHAN_HI)                          b = chan[15:8];
         else if (q == POS_CHAN_LO)                     b = chan[7:0];
         else if (q == POS_TAG)                         b = tag;
         else if (q == POS_SEQ_HI)                      b = seq[15:8];
         else if (q == POS_SEQ_LO)                      b = seq[7:0];
         else if (q == POS_LEN_HI && seq == 16'd0)      b = len[15:8];
         else if (q == POS_LEN_LO && seq == 16'd0)      b = len[7:0];
         else begin
            case (fill)
               FILL_RAMP: b = 8'(p * 37 + 11);
               FILL_ZERO: b = 8'h00;
               FILL_ONES: b = 8'hFF;
               default:   b = 8'($urandom);
            endcase
         end
         send_byte(b, typed, st, total);
      end
   endtask

   // pause until every expected item has come back, plus the result
   // register stage
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // APB setup + access; pready is honored although the block ties it high
   task automatic csr_access(input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= TAG_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      if (wr) apdu_tag_shadow = wdata[7:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // retag while idle, then read the register back
   task automatic set_apdu_tag(input logic [7:0] tag);
      logic [31:0] rd;
      wait_idle();
      csr_access(1'b1, {24'h0, tag}, rd);
      csr_access(1'b0, 32'h0, rd);
      check_field("apdu_tag readback", int'(rd), int'({24'h0, apdu_tag_shadow}));
   endtask

   // one session of random shape: mostly well-formed opening packet plus
   // continuations up to the length, sometimes a trailing packet after
   // completion; the rest noise, bad lengths, bad tags, wrong channel or
   // sequence, or an abandoned session
   task automatic random_session();
      logic [15:0] chan;
      logic [15:0] seq;
      int          len;
      int          have;
      int          roll;
      chan = 16'($urandom);
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
         send_packet(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), FILL_RANDOM);
         return;
      end
      if (roll == 1) begin
         len = $urandom_range(0, 1) ? $urandom_range(0, MIN_APDU_LEN - 1)
                                    : $urandom_range(APDU_MAX + 1, 65535);
         send_packet(chan, apdu_tag_shadow, 16'd0, 16'(len), FILL_RANDOM);
         return;
      end
      if (roll == 2) begin
         send_packet(chan, apdu_tag_shadow ^ 8'($urandom_range(1, 255)), 16'd0,
                     16'($urandom_range(MIN_APDU_LEN, 200)), FILL_RANDOM);
         return;
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(MIN_APDU_LEN, 400)
                                        : $urandom_range(MIN_APDU_LEN, 130);
      send_packet(chan, apdu_tag_shadow, 16'd0, 16'(len), FILL_RANDOM);
      have = FIRST_CAP;
      seq  = 16'd1;
      while (have < len) begin
         roll = $urandom_range(0, 15);
         if (roll == 0) begin
            send_packet(chan, apdu_tag_shadow ^ 8'($urandom_range(1, 255)), seq, 16'd0,
                        FILL_RANDOM);
            return;
         end else if (roll == 1) begin
            send_packet(chan ^ 16'($urandom_range(1, 65535)), apdu_tag_shadow, seq, 16'd0,
                        FILL_RANDOM);
            return;
         end else if (roll == 2) begin
            send_packet(chan, apdu_tag_shadow, seq + 16'($urandom_range(1, 65535)), 16'd0,
                        FILL_RANDOM);
            return;
         end else if (roll == 3) begin
            return;
         end
         send_packet(chan, apdu_tag_shadow, seq, 16'd0, FILL_RANDOM);
         have += CONT_CAP;
         seq++;
      end
      // matching packet after completion reports complete again
      if ($urandom_range(0, 3) == 0)
         send_packet(chan, apdu_tag_shadow, seq, 16'd0, FILL_RANDOM);
   endtask

   // ------------------------------------------------------------------
   // Directed table, walked right after reset with the reset tag of 5
   // ------------------------------------------------------------------
   packet_row_type dir_rows [DIR_ROWS];

   initial begin
      // continuation with no session open
      dir_rows[0]  = '{16'h0101, 8'h05, 16'd0001, 16'd0,     FILL_ZERO, 1'b1, ST_ERROR, 13'd0};
      // opening lengths out of range: below minimum, above max
      dir_rows[1]  = '{16'h0101, 8'h05, 16'd0,    16'd4,     FILL_ONES, 1'b1, ST_ERROR, 13'd0};
      dir_rows[2]  = '{16'h0101, 8'h05, 16'd0,    16'd4097,  FILL_RAMP, 1'b1, ST_ERROR, 13'd0};
      // minimum APDU fits one packet; matching packet after completion
      dir_rows[3]  = '{16'h0101, 8'h05, 16'd0,    16'd5,     FILL_RAMP, 1'b1, ST_COMPLETE, 13'd5};
      dir_rows[4]  = '{16'h0101, 8'h05, 16'd1,    16'd0,     FILL_ONES, 1'b1, ST_COMPLETE, 13'd5};
      // two-packet APDU on the top channel, surplus bytes dropped
      dir_rows[5]  = '{16'hFFFF, 8'h05, 16'd0,    16'd100,   FILL_ONES, 1'b1, ST_MORE, 13'd57};
      dir_rows[6]  = '{16'hFFFF, 8'h05, 16'd1,    16'd0,     FILL_ZERO, 1'b1, ST_COMPLETE, 13'd100};
      // bad tag clears the session, so the same sequence after it has
      // nothing to join
      dir_rows[7]  = '{16'hFFFF, 8'hFF, 16'd2,    16'd0,     FILL_RAMP, 1'b1, ST_ERROR, 13'd0};
      dir_rows[8]  = '{16'hFFFF, 8'h05, 16'd2,    16'd0,     FILL_RAMP, 1'b1, ST_ERROR, 13'd0};
      // maximum length, then wrong channel
      dir_rows[9]  = '{16'h0000, 8'h05, 16'd0,    16'd4096,  FILL_RAMP, 1'b1, ST_MORE, 13'd57};
      dir_rows[10] = '{16'h0001, 8'h05, 16'd1,    16'd0,     FILL_RAMP, 1'b1, ST_ERROR, 13'd0};
      // bad tag on an opening packet
      dir_rows[11] = '{16'h8000, 8'h00, 16'd0,    16'd10,    FILL_RAMP, 1'b1, ST_ERROR, 13'd0};
      // new opening packet mid-session restarts it, then a skipped sequence
      dir_rows[12] = '{16'h1234, 8'h05, 16'd0,    16'd200,   FILL_RAMP, 1'b1, ST_MORE, 13'd57};
      dir_rows[13] = '{16'h4321, 8'h05, 16'd0,    16'd6,     FILL_RAMP, 1'b0, ST_MORE, 13'd0};
      dir_rows[14] = '{16'h4321, 8'h05, 16'hFFFF, 16'd0,     FILL_RAMP, 1'b1, ST_ERROR, 13'd0};
      // a just-over-one-packet APDU, left to the shadow
      dir_rows[15] = '{16'h1234, 8'h05, 16'd0,    16'd64,    FILL_RAMP, 1'b0, ST_MORE, 13'd0};
      dir_rows[16] = '{16'h1234, 8'h05, 16'd1,    16'd0,     FILL_ONES, 1'b1, ST_COMPLETE, 13'd64};
   end

   // ------------------------------------------------------------------
   // Main sequence: reset, directed table, then one random session under
   // each of several tag settings (all ones, zero, random, back to reset)
   // ------------------------------------------------------------------
   initial begin
      int         i;
      int         phase_end;
      logic [7:0] tag_plan [4];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = 3'd0;
      csr_pwdata  = 32'h0;
      reset_deframer_shadow();
      tag_plan[0] = 8'hFF;
      tag_plan[1] = 8'h00;
      tag_plan[2] = 8'($urandom);
      tag_plan[3] = TAG_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIR_ROWS; i++)
         send_packet(dir_rows[i].chan, dir_rows[i].tag, dir_rows[i].seq, dir_rows[i].len,
                     dir_rows[i].fill, dir_rows[i].typed, dir_rows[i].status,
                     dir_rows[i].total);

      for (i = 0; i < 4; i++) begin
         set_apdu_tag(tag_plan[i]);
         phase_end = bytes_accepted + PACKET_BYTES;
         while (bytes_accepted < phase_end) random_session();
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** hid_apdu_packet_deframer_core: PASSED **");
      end else begin
         $display("** hid_apdu_packet_deframer_core: FAILED **");
      end
      $finish;
   end

   // watchdog well above the slowest legal run
   initial begin
      #10_000_000;
      $display("** hid_apdu_packet_deframer_core: FAILED **");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hapdu_pkg.sv
rtl/hid_apdu_packet_deframer_core.sv
tb/hid_apdu_packet_deframer_core_test.sv
